// ----- hw/rtl/recbc_pkg.sv -----
// shared types, constants and request codes for the rotary encoder counter unit
package recbc_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int TIME_WIDTH  = 32;
    localparam int STEPS_WIDTH = 16;
    localparam int SCALE_WIDTH = 8;
    localparam int DIR_WIDTH   = 2;
    localparam int MS_WIDTH    = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int BIT_CNT_W   = $clog2(COUNT_WIDTH);
    localparam int EXT_W       = ((COUNT_WIDTH > STEPS_WIDTH) ? COUNT_WIDTH : STEPS_WIDTH)
                                 + SCALE_WIDTH + 1;

    localparam logic [2:0] REQ_EDGE      = 3'd0;
    localparam logic [2:0] REQ_TICK      = 3'd1;
    localparam logic [2:0] REQ_POLL      = 3'd2;
    localparam logic [2:0] REQ_READ_FREE = 3'd3;
    localparam logic [2:0] REQ_READ_HELD = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESPONSE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE     = 2'd3;

    localparam logic [SCALE_WIDTH-1:0] SCALE_RESET    = 8'd4;
    localparam logic [DIR_WIDTH-1:0]   DIR_RESET      = 2'd1;
    localparam logic [MS_WIDTH-1:0]    RESPONSE_RESET = 16'd300;
    localparam logic [MS_WIDTH-1:0]    NOISE_RESET    = 16'd50;

    typedef struct packed {
        logic [2:0] req_type;
        logic       dt_level;
        logic       clk_level;
        logic       switch_level;
    } req_item_t;

    typedef struct packed {
        logic                          pressed;
        logic signed [STEPS_WIDTH-1:0] steps;
    } rsp_item_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ----- hw/rtl/rotary_encoder_button_counter_unit.sv -----
// top level: encoder counters, button debounce and step read sequencer
//
// Items arrive on the req channel (valid/ready) and carry a request code and the
// sampled dt, clk and switch line levels. Encoder edges and millisecond ticks
// update internal state and give no result. Button polls and step reads each
// give one item on the rsp channel (valid/ready).
// An edge or tick is applied in the accepting cycle. A poll goes straight to the
// output load, which puts its result into the output register. In a step read
// the accepting cycle launches the serial divider, which yields one quotient bit
// per cycle; the sequencer then sees it finish, saturates the quotient, writes
// back the remainder and loads the output.
// req_ready is low while an item is being worked on or while a finished result
// waits for a full output register to drain; a result already in the output
// register does not stop a new item from being accepted.
// When the receiver stalls the result is held in the output register unchanged.
// The cfg channel is always ready; writes are expected only while the block is
// idle. Reset restores the default register values and clears the counters,
// the millisecond clock and the press and release timestamps; no clearing pass.
module rotary_encoder_button_counter_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  recbc_pkg::req_item_t              req_data,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output recbc_pkg::rsp_item_t              rsp_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [recbc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [recbc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import recbc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_SAT  = 3'd2;
    localparam logic [2:0] S_FIX  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    localparam logic signed [EXT_W-1:0] STEPS_MAX_EXT = EXT_W'(2 ** (STEPS_WIDTH - 1) - 1);
    localparam logic signed [EXT_W-1:0] STEPS_MIN_EXT = -STEPS_MAX_EXT - EXT_W'(1);
    localparam logic signed [COUNT_WIDTH+1:0] COUNT_MAX_X =
        (COUNT_WIDTH + 2)'(2 ** (COUNT_WIDTH - 1) - 1);
    localparam logic signed [COUNT_WIDTH+1:0] COUNT_MIN_X = -COUNT_MAX_X - (COUNT_WIDTH + 2)'(1);

    logic [2:0]                    state_reg, state_next;
    logic [SCALE_WIDTH-1:0]        scale_reg, scale_next;
    logic signed [DIR_WIDTH-1:0]   dir_reg, dir_next;
    logic [MS_WIDTH-1:0]           response_reg, response_next;
    logic [MS_WIDTH-1:0]           noise_reg, noise_next;
    logic [TIME_WIDTH-1:0]         ms_now_reg, ms_now_next;
    logic [TIME_WIDTH-1:0]         release_reg, release_next;
    logic [TIME_WIDTH-1:0]         press_reg, press_next;
    logic signed [COUNT_WIDTH-1:0] count_free_reg, count_free_next;
    logic signed [COUNT_WIDTH-1:0] count_held_reg, count_held_next;
    logic                          sel_held_reg, sel_held_next;
    logic                          neg_reg, neg_next;
    logic signed [STEPS_WIDTH-1:0] q_sat_reg, q_sat_next;
    rsp_item_t                     res_reg, res_next;
    logic                          rsp_valid_reg, rsp_valid_next;
    rsp_item_t                     rsp_data_reg, rsp_data_next;

    logic                          accept;
    logic                          div_start;
    logic [COUNT_WIDTH-1:0]        div_dividend;
    logic [SCALE_WIDTH-1:0]        div_eff;
    div_status_t                   div_status;
    logic [COUNT_WIDTH-1:0]        div_quotient;

    logic signed [COUNT_WIDTH-1:0] cnt_pick;
    logic signed [COUNT_WIDTH-1:0] cnt_sel;
    logic signed [COUNT_WIDTH+1:0] edge_sum;
    logic signed [COUNT_WIDTH+1:0] edge_delta;
    logic signed [COUNT_WIDTH-1:0] edge_sat;
    logic signed [COUNT_WIDTH:0]   q_signed;
    logic signed [EXT_W-1:0]       q_ext;
    logic signed [EXT_W-1:0]       rem_ext;
    logic [TIME_WIDTH-1:0]         since_press;
    logic [TIME_WIDTH-1:0]         since_release;
    logic                          press_ok;

    assign accept    = req_valid && req_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    assign div_eff = (scale_reg == '0) ? SCALE_WIDTH'(1) : scale_reg;

    // counter picked by the incoming read code, and by the latched choice later on
    assign cnt_pick = (req_data.req_type == REQ_READ_HELD) ? count_held_reg : count_free_reg;
    assign cnt_sel  = sel_held_reg ? count_held_reg : count_free_reg;
    assign div_dividend = cnt_pick[COUNT_WIDTH-1] ? COUNT_WIDTH'(-cnt_pick) : cnt_pick;
    assign div_start = accept && ((req_data.req_type == REQ_READ_FREE) ||
                                  (req_data.req_type == REQ_READ_HELD));

    // encoder edge: add or subtract the direction with saturation
    always_comb
    begin
        edge_delta = (COUNT_WIDTH + 2)'(dir_reg);
        if (req_data.dt_level != req_data.clk_level)
        begin
            edge_delta = -edge_delta;
        end
        edge_sum = (req_data.switch_level ? (COUNT_WIDTH + 2)'(count_free_reg)
                                          : (COUNT_WIDTH + 2)'(count_held_reg)) + edge_delta;
        if (edge_sum > COUNT_MAX_X)
        begin
            edge_sat = COUNT_MAX_X[COUNT_WIDTH-1:0];
        end
        else if (edge_sum < COUNT_MIN_X)
        begin
            edge_sat = COUNT_MIN_X[COUNT_WIDTH-1:0];
        end
        else
        begin
            edge_sat = edge_sum[COUNT_WIDTH-1:0];
        end
    end

    assign since_press   = ms_now_reg - press_reg;
    assign since_release = ms_now_reg - release_reg;
    assign press_ok      = (since_press > TIME_WIDTH'(response_reg)) &&
                           (since_release > TIME_WIDTH'(noise_reg));

    assign q_signed = neg_reg ? -$signed({1'b0, div_quotient}) : $signed({1'b0, div_quotient});
    assign q_ext    = EXT_W'(q_signed);
    // the saturated quotient times the scale never exceeds the counter magnitude
    assign rem_ext  = EXT_W'(cnt_sel) - EXT_W'(q_sat_reg) * EXT_W'($signed({1'b0, div_eff}));

    always_comb
    begin
        state_next      = state_reg;
        scale_next      = scale_reg;
        dir_next        = dir_reg;
        response_next   = response_reg;
        noise_next      = noise_reg;
        ms_now_next     = ms_now_reg;
        release_next    = release_reg;
        press_next      = press_reg;
        count_free_next = count_free_reg;
        count_held_next = count_held_reg;
        sel_held_next   = sel_held_reg;
        neg_next        = neg_reg;
        q_sat_next      = q_sat_reg;
        res_next        = res_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_data_next   = rsp_data_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SCALE:     scale_next    = cfg_data[SCALE_WIDTH-1:0];
                CFG_DIRECTION: dir_next      = cfg_data[DIR_WIDTH-1:0];
                CFG_RESPONSE:  response_next = cfg_data[MS_WIDTH-1:0];
                CFG_NOISE:     noise_next    = cfg_data[MS_WIDTH-1:0];
                default:       ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req_data.req_type)
                        REQ_EDGE:
                        begin
                            if (req_data.switch_level)
                            begin
                                count_free_next = edge_sat;
                            end
                            else
                            begin
                                count_held_next = edge_sat;
                            end
                        end
                        REQ_TICK:
                        begin
                            ms_now_next = ms_now_reg + 1'b1;
                        end
                        REQ_POLL:
                        begin
                            res_next.pressed = 1'b0;
                            res_next.steps   = '0;
                            if (req_data.switch_level)
                            begin
                                release_next = ms_now_reg;
                            end
                            else if (press_ok)
                            begin
                                press_next       = ms_now_reg;
                                res_next.pressed = 1'b1;
                            end
                            state_next = S_DONE;
                        end
                        REQ_READ_FREE, REQ_READ_HELD:
                        begin
                            sel_held_next = (req_data.req_type == REQ_READ_HELD);
                            neg_next      = cnt_pick[COUNT_WIDTH-1];
                            state_next    = S_DIV;
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = S_SAT;
                end
            end
            S_SAT:
            begin
                if (q_ext > STEPS_MAX_EXT)
                begin
                    q_sat_next = STEPS_MAX_EXT[STEPS_WIDTH-1:0];
                end
                else if (q_ext < STEPS_MIN_EXT)
                begin
                    q_sat_next = STEPS_MIN_EXT[STEPS_WIDTH-1:0];
                end
                else
                begin
                    q_sat_next = q_ext[STEPS_WIDTH-1:0];
                end
                state_next = S_FIX;
            end
            S_FIX:
            begin
                if (sel_held_reg)
                begin
                    count_held_next = rem_ext[COUNT_WIDTH-1:0];
                end
                else
                begin
                    count_free_next = rem_ext[COUNT_WIDTH-1:0];
                end
                res_next.pressed = 1'b0;
                res_next.steps   = q_sat_reg;
                state_next       = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            scale_reg      <= SCALE_RESET;
            dir_reg        <= DIR_RESET;
            response_reg   <= RESPONSE_RESET;
            noise_reg      <= NOISE_RESET;
            ms_now_reg     <= '0;
            release_reg    <= '0;
            press_reg      <= '0;
            count_free_reg <= '0;
            count_held_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scale_reg      <= scale_next;
            dir_reg        <= dir_next;
            response_reg   <= response_next;
            noise_reg      <= noise_next;
            ms_now_reg     <= ms_now_next;
            release_reg    <= release_next;
            press_reg      <= press_next;
            count_free_reg <= count_free_next;
            count_held_reg <= count_held_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_held_reg <= sel_held_next;
        neg_reg      <= neg_next;
        q_sat_reg    <= q_sat_next;
        res_reg      <= res_next;
        rsp_data_reg <= rsp_data_next;
    end

    recbc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_eff),
        .status   (div_status),
        .quotient (div_quotient)
    );

    // divider only runs while the sequencer waits on it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_status.busy |-> (state_reg == S_DIV))
        else $error("divider busy outside the divide state");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> (state_reg == S_DIV))
        else $error("divider finished with no read in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.pressed) |-> (rsp_data.steps == '0))
        else $error("poll result carries a step count");

    // a reported press stamps the press time with the current millisecond
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_data.req_type == REQ_POLL) && !req_data.switch_level && press_ok)
        |=> (press_reg == ms_now_reg))
        else $error("press time not updated on a reported press");

endmodule

// ----- hw/rtl/recbc_div.sv -----
// serial restoring divider, one quotient bit per cycle, unsigned magnitudes
module recbc_div (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [recbc_pkg::COUNT_WIDTH-1:0]    dividend,
    input  logic [recbc_pkg::SCALE_WIDTH-1:0]    divisor,
    output recbc_pkg::div_status_t               status,
    output logic [recbc_pkg::COUNT_WIDTH-1:0]    quotient
);
    import recbc_pkg::*;

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [SCALE_WIDTH-1:0] rem_reg, rem_next;
    logic [COUNT_WIDTH-1:0] quo_reg, quo_next;
    logic [SCALE_WIDTH-1:0] divisor_reg, divisor_next;
    logic [SCALE_WIDTH:0]   trial;
    logic [SCALE_WIDTH:0]   diff;
    logic                   fits;

    assign trial = {rem_reg, quo_reg[COUNT_WIDTH-1]};
    assign diff  = trial - {1'b0, divisor_reg};
    assign fits  = (trial >= {1'b0, divisor_reg});

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        bit_cnt_next = bit_cnt_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            bit_cnt_next = BIT_CNT_W'(COUNT_WIDTH - 1);
            rem_next     = '0;
            quo_next     = dividend;
            divisor_next = divisor;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so it fits the narrow register
            rem_next = fits ? diff[SCALE_WIDTH-1:0] : trial[SCALE_WIDTH-1:0];
            quo_next = {quo_reg[COUNT_WIDTH-2:0], fits};
            if (bit_cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                bit_cnt_next = bit_cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            bit_cnt_reg <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            done_reg    <= done_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule
